// ===== design/scfe_pkg.sv =====
package scfe_pkg;

  localparam int unsigned FrameLen = 10;
  localparam int unsigned TimeoutW = 16;
  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd500;

  localparam logic [7:0] StartByte   = 8'h7E;
  localparam logic [7:0] VersionByte = 8'hFF;
  localparam logic [7:0] LengthByte  = 8'h06;
  localparam logic [7:0] EndByte     = 8'hEF;

  localparam logic [3:0] LastIdx = 4'(FrameLen - 1);

  typedef enum logic [1:0] {
    FUNC_SEND = 2'd0,
    FUNC_RX   = 2'd1,
    FUNC_TICK = 2'd2
  } func_e;

  typedef enum logic {
    KIND_TX     = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [7:0]  msg_type;
    logic [15:0] msg_arg;
    status_e     status;
  } res_t;

  // frame bytes 1 to 9, element 0 is frame byte 1
  typedef logic [FrameLen-2:0][7:0] frame_t;

  function automatic logic [15:0] frame_check(input logic [5:0][7:0] b);
    logic [15:0] sum;
    sum = 16'd0;
    for (int i = 0; i < 6; i++) begin
      sum = sum + {8'd0, b[i]};
    end
    return 16'd0 - sum;
  endfunction

endpackage

// ===== design/scfe_core.sv =====
module scfe_core
  import scfe_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [1:0]          func_i,
  input  logic [7:0]          cmd_code_i,
  input  logic [15:0]         cmd_arg_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [TimeoutW-1:0] timeout_i,
  output logic                res_valid_o,
  output res_t                res_o,
  output logic                frame_load_o,
  output frame_t              frame_o,
  output logic                waiting_o
);

  logic                waiting_q, waiting_d;
  logic [3:0]          byte_cnt_q, byte_cnt_d;
  logic [9:0][7:0]     reply_q, reply_d;
  logic [TimeoutW-1:0] elapsed_q, elapsed_d;
  logic [15:0]         tx_ck, rx_ck;
  logic                rx_bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q  <= 1'b0;
      byte_cnt_q <= 4'd0;
      reply_q    <= '0;
      elapsed_q  <= '0;
    end else if (fire_i) begin
      waiting_q  <= waiting_d;
      byte_cnt_q <= byte_cnt_d;
      reply_q    <= reply_d;
      elapsed_q  <= elapsed_d;
    end
  end

  assign tx_ck = frame_check({cmd_arg_i, 8'd0, cmd_code_i, LengthByte, VersionByte});
  assign rx_ck = frame_check(reply_q[6:1]);
  assign rx_bad = (reply_q[0] != StartByte) || (reply_q[1] != VersionByte) ||
                  (rx_byte_i != EndByte) || (reply_q[7] != rx_ck[15:8]) ||
                  (reply_q[8] != rx_ck[7:0]);

  assign frame_o = {EndByte, tx_ck[7:0], tx_ck[15:8], cmd_arg_i[7:0], cmd_arg_i[15:8],
                    8'd0, cmd_code_i, LengthByte, VersionByte};

  always_comb begin
    waiting_d    = waiting_q;
    byte_cnt_d   = byte_cnt_q;
    reply_d      = reply_q;
    elapsed_d    = elapsed_q;
    res_valid_o  = 1'b0;
    frame_load_o = 1'b0;
    res_o.kind     = KIND_REPORT;
    res_o.tx_byte  = 8'd0;
    res_o.last     = 1'b1;
    res_o.msg_type = reply_q[3];
    res_o.msg_arg  = {reply_q[5], reply_q[6]};
    res_o.status   = ST_OK;
    case (func_i)
      FUNC_SEND: begin
        res_valid_o   = 1'b1;
        frame_load_o  = 1'b1;
        res_o.kind     = KIND_TX;
        res_o.tx_byte  = StartByte;
        res_o.last     = 1'b0;
        res_o.msg_type = 8'd0;
        res_o.msg_arg  = 16'd0;
        waiting_d  = 1'b1;
        byte_cnt_d = 4'd0;
        reply_d    = '0;
        elapsed_d  = '0;
      end
      FUNC_RX: begin
        if (waiting_q) begin
          if (byte_cnt_q == 4'd0 && rx_byte_i != StartByte) begin
            byte_cnt_d = byte_cnt_q;
          end else if (byte_cnt_q == 4'd1 && rx_byte_i != VersionByte) begin
            byte_cnt_d = 4'd0;
            reply_d[0] = 8'd0;
          end else begin
            reply_d[byte_cnt_q] = rx_byte_i;
            if (byte_cnt_q == LastIdx) begin
              byte_cnt_d   = 4'd0;
              waiting_d    = 1'b0;
              res_valid_o  = 1'b1;
              res_o.status = rx_bad ? ST_INVALID : ST_OK;
            end else begin
              byte_cnt_d = byte_cnt_q + 4'd1;
            end
          end
        end
      end
      FUNC_TICK: begin
        if (waiting_q) begin
          if (elapsed_q >= timeout_i) begin
            waiting_d    = 1'b0;
            res_valid_o  = 1'b1;
            res_o.status = ST_TIMEOUT;
          end else begin
            elapsed_d = elapsed_q + 1'b1;
          end
        end
      end
      default: begin
        waiting_d = waiting_q;
      end
    endcase
  end

  assign waiting_o = waiting_q;

endmodule

// ===== design/scfe_out.sv =====
module scfe_out
  import scfe_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  res_t   res_i,
  input  logic   frame_load_i,
  input  frame_t frame_i,
  input  logic   out_ready_i,
  output logic   out_valid_o,
  output res_t   res_o,
  output logic   take_o
);

  logic       out_valid_q, out_valid_d;
  res_t       res_q, res_d;
  frame_t     frm_q, frm_d;
  logic [3:0] rem_q, rem_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;
  assign take_o    = (rem_q == 4'd0) && slot_free;

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    frm_d       = frm_q;
    rem_d       = rem_q;
    if (slot_free) begin
      if (rem_q != 4'd0) begin
        out_valid_d   = 1'b1;
        res_d         = '0;
        res_d.kind    = KIND_TX;
        res_d.tx_byte = frm_q[0];
        res_d.last    = (rem_q == 4'd1);
        frm_d         = frm_q >> 8;
        rem_d         = rem_q - 4'd1;
      end else if (load_i) begin
        out_valid_d = 1'b1;
        res_d       = res_i;
        if (frame_load_i) begin
          frm_d = frame_i;
          rem_d = LastIdx;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_q       <= 4'd0;
    end else begin
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    frm_q <= frm_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/serial_command_frame_engine.sv =====
// Ten-byte command framing engine for a serial module. A send request
// (func 0) produces ten transmit results, 7E FF 06 cmd 00argH argL ckH ckL
// EF, one per cycle while the output side takes them; input is held off
// until the final byte is presented, since the frame serializer owns the
// result register. Received bytes (func 1) and millisecond ticks (func 2)
// are taken one per cycle while the output side has room and produce at
// most one result, a response report, which is registered; the input is
// free again once the output side has room. A report carries the reply's
// type, argument and status: ok, invalid (bad terminator or checksum) or
// timeout once the ticks after a send exceed timeout_ms (register 0, reset
// 500). Bytes and ticks with no reply pending are dropped.
module serial_command_frame_engine
  import scfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  cmd_code_i,
  input  logic [15:0] cmd_arg_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [7:0]  msg_type_o,
  output logic [15:0] msg_arg_o,
  output logic [1:0]  status_o
);

  logic [TimeoutW-1:0] timeout_q;
  logic                fire, res_valid, frame_load, waiting;
  res_t                res, res_out;
  frame_t              frame;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {{(32-TimeoutW){1'b0}}, timeout_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      timeout_q <= pwdata[TimeoutW-1:0];
    end
  end

  assign fire = in_valid_i && in_ready_o;

  scfe_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .func_i       (func_i),
    .cmd_code_i   (cmd_code_i),
    .cmd_arg_i    (cmd_arg_i),
    .rx_byte_i    (rx_byte_i),
    .timeout_i    (timeout_q),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .frame_load_o (frame_load),
    .frame_o      (frame),
    .waiting_o    (waiting)
  );

  scfe_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (fire && res_valid),
    .res_i        (res),
    .frame_load_i (frame_load),
    .frame_i      (frame),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .res_o        (res_out),
    .take_o       (in_ready_o)
  );

  assign kind_o     = res_out.kind;
  assign tx_byte_o  = res_out.tx_byte;
  assign last_o     = res_out.last;
  assign msg_type_o = res_out.msg_type;
  assign msg_arg_o  = res_out.msg_arg;
  assign status_o   = res_out.status;

  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_TX && !last_o |=> out_valid_o && kind_o == KIND_TX)
    else $error("frame byte sequence broken");

  a_frame_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_TX && !last_o |-> !in_ready_o)
    else $error("request taken while frame still draining");

  a_report_on_wait_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(waiting) |-> out_valid_o && kind_o == KIND_REPORT && last_o)
    else $error("reply wait ended without a report");

endmodule

// ===== sim/serial_command_frame_engine_tb.sv =====
module serial_command_frame_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scfe_pkg::*;

  localparam logic [1:0] FuncUnused = 2'd3;
  localparam logic [1:0] TimeoutAddr = 2'd0;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 75;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  func;
    logic [7:0]  code;
    logic [15:0] arg;
    logic [7:0]  rx;
    logic        pin;
    res_t        pinned;
  } step_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready_o;
  logic [1:0]  func_i;
  logic [7:0]  cmd_code_i;
  logic [15:0] cmd_arg_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic        kind_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic [7:0]  msg_type_o;
  logic [15:0] msg_arg_o;
  logic [1:0]  status_o;

  // predictor state
  logic            awaiting_reply;
  logic [3:0]      rx_count;
  logic [9:0][7:0] reply_buf;
  logic [15:0]     tick_count;
  logic [15:0]     timeout_cfg;

  res_t  awaited_outputs[$];
  res_t  step_outputs[$];
  res_t  head_result;
  step_t cur_step;
  step_t directed[$];

  int unsigned mismatches;
  int unsigned cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  serial_command_frame_engine u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .cmd_code_i (cmd_code_i),
    .cmd_arg_i  (cmd_arg_i),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .kind_o     (kind_o),
    .tx_byte_o  (tx_byte_o),
    .last_o     (last_o),
    .msg_type_o (msg_type_o),
    .msg_arg_o  (msg_arg_o),
    .status_o   (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] neg_payload_sum(input logic [9:0][7:0] fr);
    logic [15:0] acc;
    acc = 16'd0;
    for (int i = 1; i <= 6; i++) begin
      acc = acc + {8'd0, fr[i]};
    end
    return 16'd0 - acc;
  endfunction

  function automatic res_t tx_result(input logic [7:0] b, input logic fin);
    res_t r;
    r = '0;
    r.kind = KIND_TX;
    r.tx_byte = b;
    r.last = fin;
    r.status = ST_OK;
    return r;
  endfunction

  function automatic res_t report_result(input status_e st);
    res_t r;
    r = '0;
    r.kind = KIND_REPORT;
    r.last = 1'b1;
    r.msg_type = reply_buf[3];
    r.msg_arg = {reply_buf[5], reply_buf[6]};
    r.status = st;
    return r;
  endfunction

  function automatic void predict_outputs(input step_t s);
    logic [9:0][7:0] fr;
    logic [15:0] ck;
    if (s.func == FUNC_SEND) begin
      fr = '0;
      fr[0] = StartByte;
      fr[1] = VersionByte;
      fr[2] = LengthByte;
      fr[3] = s.code;
      fr[5] = s.arg[15:8];
      fr[6] = s.arg[7:0];
      ck = neg_payload_sum(fr);
      fr[7] = ck[15:8];
      fr[8] = ck[7:0];
      fr[9] = EndByte;
      for (int i = 0; i < FrameLen; i++) begin
        step_outputs.push_back(tx_result(fr[i], i == FrameLen - 1));
      end
      awaiting_reply = 1'b1;
      rx_count = 4'd0;
      reply_buf = '0;
      tick_count = 16'd0;
    end else if (awaiting_reply && s.func == FUNC_RX) begin
      if (rx_count == 4'd1 && s.rx != VersionByte) begin
        rx_count = 4'd0;
        reply_buf[0] = 8'd0;
      end else if (rx_count != 4'd0 || s.rx == StartByte) begin
        reply_buf[rx_count] = s.rx;
        rx_count = rx_count + 4'd1;
        if (rx_count == FrameLen) begin
          rx_count = 4'd0;
          ck = neg_payload_sum(reply_buf);
          if (reply_buf[0] != StartByte || reply_buf[1] != VersionByte ||
              reply_buf[9] != EndByte || {reply_buf[7], reply_buf[8]} != ck) begin
            step_outputs.push_back(report_result(ST_INVALID));
          end else begin
            step_outputs.push_back(report_result(ST_OK));
          end
          awaiting_reply = 1'b0;
        end
      end
    end else if (awaiting_reply && s.func == FUNC_TICK) begin
      if (tick_count >= timeout_cfg) begin
        step_outputs.push_back(report_result(ST_TIMEOUT));
        awaiting_reply = 1'b0;
      end else begin
        tick_count = tick_count + 16'd1;
      end
    end
  endfunction

  function automatic step_t mk_step(input logic [1:0] f, input logic [7:0] c,
                                    input logic [15:0] a, input logic [7:0] b);
    step_t s;
    s = '0;
    s.func = f;
    s.code = c;
    s.arg = a;
    s.rx = b;
    return s;
  endfunction

  function automatic step_t cfg_step(input logic [15:0] v);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.arg = v;
    return s;
  endfunction

  function automatic step_t pin_report(input step_t s, input logic [7:0] t,
                                       input logic [15:0] a, input status_e st);
    step_t r;
    r = s;
    r.pin = 1'b1;
    r.pinned = '0;
    r.pinned.kind = KIND_REPORT;
    r.pinned.last = 1'b1;
    r.pinned.msg_type = t;
    r.pinned.msg_arg = a;
    r.pinned.status = st;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(negedge clk_i) begin
    out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (awaited_outputs.size() == 0) begin
          $display("%0t: unexpected result, expected none actual kind %0d byte %h status %0d",
                   $time, kind_o, tx_byte_o, status_o);
          mismatches++;
        end else begin
          head_result = awaited_outputs.pop_front();
          check_field("kind", 16'(head_result.kind), 16'(kind_o));
          check_field("tx_byte", 16'(head_result.tx_byte), 16'(tx_byte_o));
          check_field("last", 16'(head_result.last), 16'(last_o));
          check_field("msg_type", 16'(head_result.msg_type), 16'(msg_type_o));
          check_field("msg_arg", head_result.msg_arg, msg_arg_o);
          check_field("status", 16'(head_result.status), 16'(status_o));
        end
      end
      if (in_valid && in_ready_o) begin
        step_outputs.delete();
        predict_outputs(cur_step);
        if (cur_step.pin) begin
          awaited_outputs.push_back(cur_step.pinned);
        end else begin
          foreach (step_outputs[i]) awaited_outputs.push_back(step_outputs[i]);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("serial_command_frame_engine_tb failed");
      $finish;
    end
  end

  task automatic issue_request(input step_t s);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    cur_step = s;
    func_i = s.func;
    cmd_code_i = s.code;
    cmd_arg_i = s.arg;
    rx_byte_i = s.rx;
    in_valid = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic set_timeout(input logic [15:0] v);
    @(negedge clk_i);
    in_valid = 1'b0;
    while (awaited_outputs.size() != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = TimeoutAddr;
    pwdata = {16'd0, v};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    timeout_cfg = v;
    @(negedge clk_i);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {16'd0, v}) begin
      $display("%0t: timeout readback mismatch, expected %h actual %h",
               $time, {16'd0, v}, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic run_exchange(output int unsigned n);
    logic [9:0][7:0] rep;
    logic [15:0] ck;
    logic [7:0] b;
    int unsigned pick;
    int unsigned cut;
    int unsigned ticks;
    n = 1;
    pick = $urandom_range(0, 9);
    issue_request(mk_step(FUNC_SEND, 8'($urandom), 16'($urandom), 8'($urandom)));
    if (pick == 9) begin
      // unsynced chatter while waiting
      repeat ($urandom_range(1, 8)) begin
        issue_request(mk_step(2'($urandom_range(1, 3)), 8'($urandom), 16'($urandom),
                              8'($urandom)));
        n++;
      end
    end else begin
      rep[0] = StartByte;
      rep[1] = VersionByte;
      rep[2] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : LengthByte;
      for (int i = 3; i < 7; i++) begin
        rep[i] = 8'($urandom);
      end
      ck = neg_payload_sum(rep);
      rep[7] = ck[15:8];
      rep[8] = ck[7:0];
      rep[9] = EndByte;
      if (pick == 6) begin
        cut = $urandom_range(2, 9);
        rep[cut] = rep[cut] ^ 8'($urandom_range(1, 255));
      end
      if (pick == 8) begin
        // start byte followed by a bad second byte
        issue_request(mk_step(FUNC_RX, 8'd0, 16'd0, StartByte));
        b = ($urandom_range(0, 1) == 1) ? StartByte : 8'($urandom);
        if (b == VersionByte) b = 8'h00;
        issue_request(mk_step(FUNC_RX, 8'd0, 16'd0, b));
        n += 2;
      end
      repeat ($urandom_range(0, 2)) begin
        b = 8'($urandom);
        if (b == StartByte) b = ~b;
        issue_request(mk_step(FUNC_RX, 8'd0, 16'd0, b));
        n++;
      end
      cut = (pick == 7) ? $urandom_range(0, 9) : FrameLen;
      for (int i = 0; i < cut; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          issue_request(mk_step(FUNC_TICK, 8'($urandom), 16'($urandom), 8'($urandom)));
          n++;
        end
        issue_request(mk_step(FUNC_RX, 8'($urandom), 16'($urandom), rep[i]));
        n++;
      end
      if (pick == 7) begin
        ticks = (timeout_cfg <= 16'd40) ? int'(timeout_cfg) + 1 : $urandom_range(1, 4);
        repeat (ticks) begin
          issue_request(mk_step(FUNC_TICK, 8'($urandom), 16'($urandom), 8'($urandom)));
          n++;
        end
      end
    end
  endtask

  initial begin
    logic [7:0] good_reply [10];
    logic [15:0] tmo;
    int unsigned done;
    int unsigned n;
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 30;
    recv_idle_pct = 70;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 2'd0;
    pwdata = 32'd0;
    in_valid = 1'b0;
    func_i = FUNC_SEND;
    cmd_code_i = 8'd0;
    cmd_arg_i = 16'd0;
    rx_byte_i = 8'd0;
    cur_step = '0;
    awaiting_reply = 1'b0;
    rx_count = 4'd0;
    reply_buf = '0;
    tick_count = 16'd0;
    timeout_cfg = TimeoutReset;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    good_reply = '{8'h7E, 8'hFF, 8'h06, 8'h3F, 8'h00, 8'h12, 8'h34, 8'hFE, 8'h76, 8'hEF};
    // ignored while idle
    directed.push_back(mk_step(FUNC_TICK, 8'h00, 16'h0000, 8'h00));
    directed.push_back(mk_step(FUNC_RX, 8'h00, 16'h0000, 8'h7E));
    directed.push_back(mk_step(FuncUnused, 8'hFF, 16'hFFFF, 8'hFF));
    directed.push_back(mk_step(FUNC_SEND, 8'h00, 16'h0000, 8'h00));
    // resend while waiting
    directed.push_back(mk_step(FUNC_SEND, 8'hFF, 16'hFFFF, 8'h00));
    directed.push_back(mk_step(FUNC_RX, 8'h00, 16'h0000, 8'h00));
    directed.push_back(mk_step(FUNC_RX, 8'h00, 16'h0000, 8'h7E));
    directed.push_back(mk_step(FUNC_RX, 8'h00, 16'h0000, 8'h12));
    for (int i = 0; i < 9; i++) begin
      directed.push_back(mk_step(FUNC_RX, 8'h00, 16'h0000, good_reply[i]));
    end
    directed.push_back(pin_report(mk_step(FUNC_RX, 8'h00, 16'h0000, good_reply[9]),
                                  8'h3F, 16'h1234, ST_OK));
    // zero timeout, partial reply reported on first tick
    directed.push_back(cfg_step(16'd0));
    directed.push_back(mk_step(FUNC_SEND, 8'h01, 16'h0001, 8'h00));
    directed.push_back(mk_step(FUNC_RX, 8'h00, 16'h0000, 8'h7E));
    directed.push_back(mk_step(FUNC_RX, 8'h00, 16'h0000, 8'hFF));
    directed.push_back(mk_step(FUNC_RX, 8'h00, 16'h0000, 8'h06));
    directed.push_back(mk_step(FUNC_RX, 8'h00, 16'h0000, 8'hAA));
    directed.push_back(pin_report(mk_step(FUNC_TICK, 8'h00, 16'h0000, 8'h00),
                                  8'hAA, 16'h0000, ST_TIMEOUT));

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        set_timeout(directed[i].arg);
      end else begin
        issue_request(directed[i]);
      end
    end

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase)
        0: tmo = 16'd3;
        1: tmo = 16'd0;
        2: tmo = 16'hFFFF;
        3: tmo = 16'd1;
        4: tmo = 16'($urandom_range(2, 12));
        default: tmo = TimeoutReset;
      endcase
      set_timeout(tmo);
      done = 0;
      while (done < PhaseItems) begin
        run_exchange(n);
        done += n;
      end
    end

    @(negedge clk_i);
    in_valid = 1'b0;
    while (awaited_outputs.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("serial_command_frame_engine_tb passed");
    end else begin
      $display("serial_command_frame_engine_tb failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/scfe_pkg.sv
design/scfe_core.sv
design/scfe_out.sv
design/serial_command_frame_engine.sv
sim/serial_command_frame_engine_tb.sv
